// ===== rtl/rsp_pkg.sv =====
// shared types and constants of the ring stepper positioner
`timescale 1ns / 1ps

package rsp_pkg;

    localparam int unsigned POS_W   = 8;
    localparam int unsigned DELAY_W = 8;
    localparam int unsigned RATE_W  = 4;
    localparam int unsigned DIST_W  = 7;
    localparam int unsigned COIL_W  = 6;
    localparam int unsigned PHASE_W = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 24;

    localparam logic [POS_W-1:0] RING_STEPS = 8'd200;
    localparam logic [POS_W-1:0] LAST_POS   = 8'd199;
    localparam logic [POS_W-1:0] HALF_RING  = 8'd100;
    localparam logic [POS_W-1:0] FAR_DIST   = 8'd30;
    localparam logic signed [POS_W:0] HALF_S     = 9'sd100;
    localparam logic signed [POS_W:0] NEG_HALF_S = -9'sd100;

    localparam logic [DELAY_W-1:0] DELAY_MIN_SAT = 8'd1;
    localparam logic [DELAY_W-1:0] DELAY_MAX_SAT = 8'd255;

    localparam logic [DELAY_W-1:0] MAX_DELAY_RST = 8'd20;
    localparam logic [DELAY_W-1:0] MIN_DELAY_RST = 8'd6;
    localparam logic [RATE_W-1:0]  RAMP_RATE_RST = 4'd1;
    localparam logic [DIST_W-1:0]  DECEL_RST     = 7'd15;
    localparam logic [DIST_W-1:0]  NEAR_RST      = 7'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_RATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR      = 3'd4;

    localparam logic [COIL_W-1:0] COIL_TABLE [4] = '{6'h30, 6'h06, 6'h28, 6'h05};

    typedef struct packed {
        logic [DELAY_W-1:0] max_delay;
        logic [DELAY_W-1:0] min_delay;
        logic [RATE_W-1:0]  ramp_rate;
        logic [DIST_W-1:0]  decel_distance;
        logic [DIST_W-1:0]  near_distance;
    } rsp_cfg_t;

    typedef struct packed {
        logic [COIL_W-1:0]  coil_pattern;
        logic [POS_W-1:0]   position;
        logic               stepped;
        logic               near_goal;
        logic [DELAY_W-1:0] step_delay;
    } rsp_result_t;

endpackage

// ===== rtl/rsp_cfg_regs.sv =====
// configuration register file of the ring stepper positioner
`timescale 1ns / 1ps

module rsp_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rsp_pkg::CFG_DATA_W-1:0] cfg_data,
    output rsp_pkg::rsp_cfg_t              cfg
);
    import rsp_pkg::*;

    rsp_cfg_t cfg_reg;
    rsp_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MAX_DELAY: cfg_next.max_delay      = cfg_data;
                CFG_MIN_DELAY: cfg_next.min_delay      = cfg_data;
                CFG_RAMP_RATE: cfg_next.ramp_rate      = cfg_data[RATE_W-1:0];
                CFG_DECEL:     cfg_next.decel_distance = cfg_data[DIST_W-1:0];
                CFG_NEAR:      cfg_next.near_distance  = cfg_data[DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_delay      <= MAX_DELAY_RST;
            cfg_reg.min_delay      <= MIN_DELAY_RST;
            cfg_reg.ramp_rate      <= RAMP_RATE_RST;
            cfg_reg.decel_distance <= DECEL_RST;
            cfg_reg.near_distance  <= NEAR_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/rsp_step_core.sv =====
// tick counter, ring stepping, coil phase and delay ramp state
`timescale 1ns / 1ps

module rsp_step_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      advance,
    input  logic [rsp_pkg::POS_W-1:0] goal_position,
    input  logic                      run,
    input  rsp_pkg::rsp_cfg_t         cfg,
    output rsp_pkg::rsp_result_t      result
);
    import rsp_pkg::*;

    logic [POS_W-1:0]   step_pos_reg,   step_pos_next;
    logic [PHASE_W-1:0] coil_phase_reg, coil_phase_next;
    logic [DELAY_W-1:0] delay_reg,      delay_next;
    logic [DELAY_W-1:0] tick_reg,       tick_next;
    logic               near_reg,       near_next;

    logic [POS_W-1:0]   goal_sat;
    logic [DELAY_W:0]   tick_inc;
    logic               step_event;
    logic signed [POS_W:0] diff;
    logic [POS_W-1:0]   dist_abs;
    logic [POS_W-1:0]   ring_dist;
    logic               go_fwd;
    logic               go_back;
    logic [DELAY_W:0]   rate_plus_one;
    logic [DELAY_W:0]   delay_up;
    logic [DELAY_W-1:0] delay_ramped;

    always_comb begin
        goal_sat   = (goal_position >= RING_STEPS) ? LAST_POS : goal_position;
        tick_inc   = {1'b0, tick_reg} + 9'd1;
        step_event = run && (tick_inc >= {1'b0, delay_reg});

        diff      = $signed({1'b0, goal_sat}) - $signed({1'b0, step_pos_reg});
        dist_abs  = diff[POS_W] ? POS_W'(-diff) : diff[POS_W-1:0];
        ring_dist = (dist_abs > HALF_RING) ? RING_STEPS - dist_abs : dist_abs;

        go_fwd  = (diff > 9'sd0 && diff < HALF_S) || (diff < NEG_HALF_S);
        go_back = (diff < 9'sd0 && diff >= NEG_HALF_S) || (diff >= HALF_S);

        rate_plus_one = {5'd0, cfg.ramp_rate} + 9'd1;
        delay_up      = {1'b0, delay_reg} + {5'd0, cfg.ramp_rate};
        // far away: accelerate, close in: slow down, saturate to 1..255
        if (ring_dist > FAR_DIST && delay_reg > cfg.min_delay) begin
            delay_ramped = ({1'b0, delay_reg} > rate_plus_one)
                         ? delay_reg - {4'd0, cfg.ramp_rate} : DELAY_MIN_SAT;
        end else if (ring_dist < {1'b0, cfg.decel_distance} && delay_reg <= cfg.max_delay) begin
            delay_ramped = delay_up[DELAY_W] ? DELAY_MAX_SAT : delay_up[DELAY_W-1:0];
        end else begin
            delay_ramped = delay_reg;
        end

        step_pos_next   = step_pos_reg;
        coil_phase_next = coil_phase_reg;
        delay_next      = delay_reg;
        tick_next       = tick_reg;
        near_next       = near_reg;

        if (run) begin
            if (step_event) begin
                tick_next  = '0;
                near_next  = ring_dist < {1'b0, cfg.near_distance};
                delay_next = delay_ramped;
                if (go_fwd) begin
                    step_pos_next   = (step_pos_reg == LAST_POS) ? '0 : step_pos_reg + 8'd1;
                    coil_phase_next = coil_phase_reg + 2'd1;
                end else if (go_back) begin
                    step_pos_next   = (step_pos_reg == '0) ? LAST_POS : step_pos_reg - 8'd1;
                    coil_phase_next = coil_phase_reg - 2'd1;
                end
            end else begin
                tick_next = tick_inc[DELAY_W-1:0];
            end
        end

        result.coil_pattern = COIL_TABLE[coil_phase_next];
        result.position     = step_pos_next;
        result.stepped      = step_event;
        result.near_goal    = near_next;
        result.step_delay   = delay_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_pos_reg   <= '0;
            coil_phase_reg <= '0;
            delay_reg      <= MAX_DELAY_RST;
            tick_reg       <= '0;
            near_reg       <= 1'b0;
        end else if (advance) begin
            step_pos_reg   <= step_pos_next;
            coil_phase_reg <= coil_phase_next;
            delay_reg      <= delay_next;
            tick_reg       <= tick_next;
            near_reg       <= near_next;
        end
    end

endmodule

// ===== rtl/ring_stepper_positioner.sv =====
// top level of the ring stepper positioner
`timescale 1ns / 1ps

// Stepper position controller on a 200-step ring. Each input item is one
// prescaler tick with a goal position and a run flag; each tick yields one
// result item with the coil pattern, position, step flag, near-goal flag and
// current step delay. One item is taken every clock cycle while the downstream
// side does not stall. An accepted item waits in the input register; when the
// result register is free or being emptied, its result is registered there and
// presented on the result port. The per-tick state update (counter compare,
// shortest ring distance, step and delay ramp) is combinational, so ticks may
// come back to back. The result register holds a finished item while the
// downstream side stalls and the input register keeps taking items until both
// are full. Configuration is written through cfg_valid/cfg_index/cfg_data,
// always ready; write only while no item is in flight.
module ring_stepper_positioner (
    input  logic                             aclk,
    input  logic                             aresetn,
    // config write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rsp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rsp_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input items
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [rsp_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // goal_position, run
    // result items
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [rsp_pkg::OUT_DATA_W-1:0]   m_axis_tdata   // coil_pattern, position,
                                                            // stepped, near_goal, step_delay
);
    import rsp_pkg::*;

    rsp_cfg_t    cfg;
    rsp_result_t result;

    logic             in_valid_reg;
    logic [POS_W-1:0] in_goal_reg;
    logic             in_run_reg;
    logic             out_valid_reg;
    rsp_result_t      out_reg;
    logic             advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    rsp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rsp_step_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .goal_position (in_goal_reg),
        .run           (in_run_reg),
        .cfg           (cfg),
        .result        (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_goal_reg <= s_axis_tdata[POS_W-1:0];
            in_run_reg  <= s_axis_tdata[POS_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.step_delay, out_reg.near_goal, out_reg.stepped,
                            out_reg.position, out_reg.coil_pattern};

endmodule

// ===== sim/ring_stepper_positioner_test.sv =====
// self-checking testbench of the ring stepper positioner with its own motion predictor
`timescale 1ns / 1ps

module ring_stepper_positioner_test;

    import rsp_pkg::*;

    localparam int RING_SIZE   = 200;
    localparam int HALF_STEPS  = 100;
    localparam int FAR_STEPS   = 30;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [5:0] COIL_DRIVE [4] = '{6'h30, 6'h06, 6'h28, 6'h05};

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // goal_position, run
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // coil_pattern, position, stepped, near_goal, step_delay

    // predicted motor state and register copy
    rsp_cfg_t    cfg_now;
    logic [7:0]  pos_now;
    logic [1:0]  phase_now;
    logic [7:0]  delay_now;
    logic [7:0]  tick_now;
    logic        near_now;

    rsp_result_t expected_ticks [$];
    int          fail_count;
    int          quiet_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;

    ring_stepper_positioner i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic rsp_result_t advance_motor(input logic [7:0] goal_raw, input logic run);
        rsp_result_t r;
        int goal;
        int diff;
        int ring_dist;
        int d;
        int rate;
        goal = (goal_raw >= RING_SIZE) ? RING_SIZE - 1 : int'(goal_raw);
        rate = int'(cfg_now.ramp_rate);
        r.stepped = 1'b0;
        if (run) begin
            if (int'(tick_now) + 1 >= int'(delay_now)) begin
                tick_now = 8'd0;
                r.stepped = 1'b1;
                diff = goal - int'(pos_now);
                ring_dist = (diff < 0) ? -diff : diff;
                if (ring_dist > HALF_STEPS) begin
                    ring_dist = RING_SIZE - ring_dist;
                end
                near_now = (ring_dist < int'(cfg_now.near_distance));
                if ((diff > 0 && diff < HALF_STEPS) || diff < -HALF_STEPS) begin
                    pos_now   = (int'(pos_now) + 1 >= RING_SIZE) ? 8'd0 : pos_now + 8'd1;
                    phase_now = phase_now + 2'd1;
                end else if ((diff < 0 && diff >= -HALF_STEPS) || diff >= HALF_STEPS) begin
                    pos_now   = (pos_now == 8'd0) ? 8'(RING_SIZE - 1) : pos_now - 8'd1;
                    phase_now = phase_now - 2'd1;
                end
                d = int'(delay_now);
                if (ring_dist > FAR_STEPS && d > int'(cfg_now.min_delay)) begin
                    d = (d > rate + 1) ? d - rate : 1;
                end else if (ring_dist < int'(cfg_now.decel_distance) &&
                             d <= int'(cfg_now.max_delay)) begin
                    d = (d + rate > 255) ? 255 : d + rate;
                end
                delay_now = 8'(d);
            end else begin
                tick_now = tick_now + 8'd1;
            end
        end
        r.coil_pattern = COIL_DRIVE[phase_now];
        r.position     = pos_now;
        r.near_goal    = near_now;
        r.step_delay   = delay_now;
        return r;
    endfunction

    // goal mostly around the predicted position so both directions and wraps come up
    function automatic logic [7:0] pick_goal();
        int off;
        case ($urandom_range(0, 9))
            0: off = 0;
            1: off = 1;
            2: off = -1;
            3: off = HALF_STEPS - 1;
            4: off = HALF_STEPS;
            5: off = -HALF_STEPS;
            6: off = HALF_STEPS + 1;
            7: return 8'($urandom_range(RING_SIZE, 255));
            8: off = FAR_STEPS + $urandom_range(0, 1);
            default: return 8'($urandom_range(0, 255));
        endcase
        return 8'(((int'(pos_now) + off) % RING_SIZE + RING_SIZE) % RING_SIZE);
    endfunction

    task automatic send_tick(input logic [7:0] goal, input logic run);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tdata  <= {7'd0, run, goal};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        expected_ticks.push_back(advance_motor(goal, run));
        @(negedge aclk);
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        while (expected_ticks.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_MAX_DELAY: cfg_now.max_delay      = value;
            CFG_MIN_DELAY: cfg_now.min_delay      = value;
            CFG_RAMP_RATE: cfg_now.ramp_rate      = value[3:0];
            CFG_DECEL:     cfg_now.decel_distance = value[6:0];
            CFG_NEAR:      cfg_now.near_distance  = value[6:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic set_config(input logic [7:0] max_d, input logic [7:0] min_d,
                              input logic [3:0] rate, input logic [6:0] decel,
                              input logic [6:0] near);
        wait_all_results();
        write_register(CFG_MAX_DELAY, max_d);
        write_register(CFG_MIN_DELAY, min_d);
        write_register(CFG_RAMP_RATE, {4'd0, rate});
        write_register(CFG_DECEL, {1'b0, decel});
        write_register(CFG_NEAR, {1'b0, near});
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_hold();
        send_tick(8'd0, 1'b0);
        send_tick(8'd255, 1'b0);
        send_tick(8'd0, 1'b1);
        wait_all_results();
    endtask

    // goal lies exactly half a ring away, so the first step goes backward across zero
    task automatic test_extreme_registers();
        set_config(8'd255, 8'd0, 4'd15, 7'd127, 7'd127);
        repeat (20) send_tick(8'd100, 1'b1);
        send_tick(8'd200, 1'b0);
        send_tick(8'd250, 1'b1);
        wait_all_results();
    endtask

    task automatic test_random_motion(input int n_ticks);
        int sent;
        int hold;
        logic [7:0] goal;
        sent = 0;
        while (sent < n_ticks) begin
            goal = pick_goal();
            hold = $urandom_range(3, 30);
            if (hold > n_ticks - sent) begin
                hold = n_ticks - sent;
            end
            repeat (hold) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_tick(8'($urandom_range(0, 255)), 1'b1);
                end else begin
                    send_tick(goal, $urandom_range(0, 9) != 0);
                end
                sent++;
            end
        end
        wait_all_results();
    endtask

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        rsp_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_ticks.size() == 0) begin
                $display("%0t: result item with none expected, expected none actual %h",
                         $time, m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_ticks.pop_front();
                check_field("coil_pattern", want.coil_pattern, m_axis_tdata[5:0]);
                check_field("position", want.position, m_axis_tdata[13:6]);
                check_field("stepped", want.stepped, m_axis_tdata[14]);
                check_field("near_goal", want.near_goal, m_axis_tdata[15]);
                check_field("step_delay", want.step_delay, m_axis_tdata[23:16]);
            end
        end
    end

    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        fail_count     = 0;
        quiet_cycles   = 0;
        cfg_now        = '{max_delay: 8'd20, min_delay: 8'd6, ramp_rate: 4'd1,
                           decel_distance: 7'd15, near_distance: 7'd5};
        pos_now        = 8'd0;
        phase_now      = 2'd0;
        delay_now      = 8'd20;
        tick_now       = 8'd0;
        near_now       = 1'b0;
        send_idle_pct  = 34;
        recv_stall_pct = 67;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_hold();
        test_extreme_registers();
        set_config(8'd8, 8'd1, 4'd1, 7'd10, 7'd3);
        test_random_motion(92);
        set_config(8'd0, 8'd0, 4'd15, 7'd0, 7'd0);
        test_random_motion(92);

        send_idle_pct  = 67;
        recv_stall_pct = 34;
        set_config(8'd12, 8'd255, 4'd2, 7'd20, 7'd8);
        test_random_motion(92);
        set_config(8'd40, 8'd4, 4'd0, 7'd50, 7'd20);
        test_random_motion(92);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_config(8'd60, 8'd2, 4'd7, 7'd127, 7'd127);
        test_random_motion(92);
        set_config(8'd20, 8'd6, 4'd1, 7'd15, 7'd5);
        test_random_motion(92);

        wait_all_results();
        repeat (8) @(negedge aclk);
        if (fail_count == 0 && expected_ticks.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rsp_pkg.sv
rtl/rsp_cfg_regs.sv
rtl/rsp_step_core.sv
rtl/ring_stepper_positioner.sv
sim/ring_stepper_positioner_test.sv
